/* rtl/sil_pkg.sv */
// Shared types for the sorted index list manager.
`default_nettype none
package sil_pkg;

   typedef enum logic [1:0] {
      OP_ALLOCATE = 2'd0,
      OP_FREE     = 2'd1,
      OP_INSERT   = 2'd2,
      OP_REMOVE   = 2'd3
   } sil_op_type;

   typedef struct packed {
      logic       status;
      logic [7:0] allocated_index;
      logic [7:0] active_count;
   } sil_result_type;

endpackage
`default_nettype wire

/* rtl/sil_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module sil_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

/* rtl/sil_list_ctrl.sv */
// Link table sequencer: clearing pass, allocate, sorted link and unlink.
`default_nettype none
module sil_list_ctrl #(
   parameter int ENTRIES     = 256,
   parameter int FIRST_INDEX = 1
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [1:0]              req_operation,
   input  wire logic [7:0]              req_entry_index,
   output logic                         done_valid,
   input  wire logic                    done_take,
   output sil_pkg::sil_result_type      done_result
);
   import sil_pkg::*;

   localparam int IW = $clog2(ENTRIES);
   localparam int SW = $clog2(ENTRIES + 1);
   localparam int FreeReset = (FIRST_INDEX < ENTRIES) ? FIRST_INDEX : 0;

   typedef enum logic [10:0] {
      ST_INIT      = 11'b00000000001,
      ST_IDLE      = 11'b00000000010,
      ST_ALLOC_RD  = 11'b00000000100,
      ST_ALLOC_WR  = 11'b00000001000,
      ST_WALK      = 11'b00000010000,
      ST_WALK_WAIT = 11'b00000100000,
      ST_LINK1     = 11'b00001000000,
      ST_LINK2     = 11'b00010000000,
      ST_REM_RD    = 11'b00100000000,
      ST_REM_WR    = 11'b01000000000,
      ST_DONE      = 11'b10000000000
   } state_type;

   state_type   state_ff, state_in;
   sil_op_type  op_ff, op_in;
   logic [IW-1:0] e_ff, e_in;
   logic [IW-1:0] p_ff, p_in;
   logic [IW-1:0] n_ff, n_in;
   logic [SW-1:0] steps_ff, steps_in;
   logic [IW-1:0] init_ff, init_in;
   logic [IW-1:0] free_head_ff, free_head_in;
   logic [IW-1:0] active_head_ff, active_head_in;
   logic [7:0]    active_total_ff, active_total_in;
   logic          status_ff, status_in;
   logic [7:0]    given_ff, given_in;

   logic          next_wr_en, prev_wr_en;
   logic [IW-1:0] next_wr_addr, prev_wr_addr;
   logic [IW-1:0] next_wr_data, prev_wr_data;
   logic [IW-1:0] next_rd_addr;
   logic [IW-1:0] next_rd_data, prev_rd_data;

   logic [IW+7:0] req_wide;
   logic [IW-1:0] req_idx;
   logic          req_ok;
   logic [IW+7:0] head_wide;
   logic [31:0]   init_wide;
   logic          walk_go;

   sil_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_next_ram (
      .clock   (clock),
      .wr_en   (next_wr_en),
      .wr_addr (next_wr_addr),
      .wr_data (next_wr_data),
      .rd_addr (next_rd_addr),
      .rd_data (next_rd_data)
   );

   sil_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_prev_ram (
      .clock   (clock),
      .wr_en   (prev_wr_en),
      .wr_addr (prev_wr_addr),
      .wr_data (prev_wr_data),
      .rd_addr (e_ff),
      .rd_data (prev_rd_data)
   );

   assign req_wide  = {{IW{1'b0}}, req_entry_index};
   assign req_idx   = req_wide[IW-1:0];
   assign req_ok    = (req_entry_index != 8'd0) && (32'(req_entry_index) < 32'(ENTRIES));
   assign head_wide = {8'd0, free_head_ff};
   assign init_wide = 32'(init_ff);
   assign walk_go   = (n_ff != '0) && (n_ff < e_ff) && (steps_ff < SW'(ENTRIES));

   assign req_stall   = (state_ff != ST_IDLE);
   assign done_valid  = (state_ff == ST_DONE);
   assign done_result = '{status: status_ff, allocated_index: given_ff,
                          active_count: active_total_ff};

   always_comb begin
      state_in        = state_ff;
      op_in           = op_ff;
      e_in            = e_ff;
      p_in            = p_ff;
      n_in            = n_ff;
      steps_in        = steps_ff;
      init_in         = init_ff;
      free_head_in    = free_head_ff;
      active_head_in  = active_head_ff;
      active_total_in = active_total_ff;
      status_in       = status_ff;
      given_in        = given_ff;
      next_wr_en      = 1'b0;
      next_wr_addr    = e_ff;
      next_wr_data    = n_ff;
      prev_wr_en      = 1'b0;
      prev_wr_addr    = e_ff;
      prev_wr_data    = p_ff;
      next_rd_addr    = n_ff;
      case (state_ff)
         ST_INIT: begin
            next_wr_en   = 1'b1;
            prev_wr_en   = 1'b1;
            next_wr_addr = init_ff;
            prev_wr_addr = init_ff;
            next_wr_data = ((init_wide >= 32'(FIRST_INDEX)) &&
                            (init_wide < 32'(ENTRIES - 1))) ? init_ff + 1'b1 : '0;
            prev_wr_data = (init_wide > 32'(FIRST_INDEX)) ? init_ff - 1'b1 : '0;
            init_in      = init_ff + 1'b1;
            if (init_wide == 32'(ENTRIES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               op_in     = sil_op_type'(req_operation);
               e_in      = req_idx;
               status_in = 1'b0;
               given_in  = 8'd0;
               p_in      = '0;
               steps_in  = '0;
               n_in      = (sil_op_type'(req_operation) == OP_FREE) ?
                           free_head_ff : active_head_ff;
               case (sil_op_type'(req_operation))
                  OP_ALLOCATE: state_in = ST_ALLOC_RD;
                  OP_REMOVE:   state_in = req_ok ? ST_REM_RD : ST_DONE;
                  default:     state_in = req_ok ? ST_WALK : ST_DONE;
               endcase
            end
         end
         ST_ALLOC_RD: begin
            next_rd_addr = free_head_ff;
            if (free_head_ff == '0) begin
               status_in = 1'b1;
               state_in  = ST_DONE;
            end else begin
               given_in = head_wide[7:0];
               state_in = ST_ALLOC_WR;
            end
         end
         ST_ALLOC_WR: begin
            free_head_in = next_rd_data;
            prev_wr_en   = (next_rd_data != '0);
            prev_wr_addr = next_rd_data;
            prev_wr_data = '0;
            state_in     = ST_DONE;
         end
         ST_WALK: begin
            if (walk_go) begin
               next_rd_addr = n_ff;
               p_in         = n_ff;
               steps_in     = steps_ff + 1'b1;
               state_in     = ST_WALK_WAIT;
            end else begin
               state_in = ST_LINK1;
            end
         end
         ST_WALK_WAIT: begin
            n_in     = next_rd_data;
            state_in = ST_WALK;
         end
         ST_LINK1: begin
            next_wr_en   = 1'b1;
            next_wr_addr = e_ff;
            next_wr_data = n_ff;
            prev_wr_en   = 1'b1;
            prev_wr_addr = e_ff;
            prev_wr_data = p_ff;
            state_in     = ST_LINK2;
         end
         ST_LINK2: begin
            next_wr_en   = (p_ff != '0);
            next_wr_addr = p_ff;
            next_wr_data = e_ff;
            prev_wr_en   = (n_ff != '0);
            prev_wr_addr = n_ff;
            prev_wr_data = e_ff;
            if (p_ff == '0) begin
               if (op_ff == OP_FREE) begin
                  free_head_in = e_ff;
               end else begin
                  active_head_in = e_ff;
               end
            end
            if (op_ff == OP_INSERT) begin
               active_total_in = active_total_ff + 8'd1;
            end
            state_in = ST_DONE;
         end
         ST_REM_RD: begin
            next_rd_addr = e_ff;
            state_in     = ST_REM_WR;
         end
         ST_REM_WR: begin
            next_wr_en   = (prev_rd_data != '0);
            next_wr_addr = prev_rd_data;
            next_wr_data = next_rd_data;
            prev_wr_en   = (next_rd_data != '0);
            prev_wr_addr = next_rd_data;
            prev_wr_data = prev_rd_data;
            if (prev_rd_data == '0) begin
               active_head_in = next_rd_data;
            end
            active_total_in = active_total_ff - 8'd1;
            state_in        = ST_DONE;
         end
         ST_DONE: begin
            if (done_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_INIT;
         init_ff         <= '0;
         free_head_ff    <= IW'(FreeReset);
         active_head_ff  <= '0;
         active_total_ff <= 8'd0;
      end else begin
         state_ff        <= state_in;
         init_ff         <= init_in;
         free_head_ff    <= free_head_in;
         active_head_ff  <= active_head_in;
         active_total_ff <= active_total_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      e_ff      <= e_in;
      p_ff      <= p_in;
      n_ff      <= n_in;
      steps_ff  <= steps_in;
      status_ff <= status_in;
      given_ff  <= given_in;
   end

endmodule
`default_nettype wire

/* rtl/sorted_index_list_manager.sv */
// Sorted index list manager top level with response output register.
//
// Requests (req_operation, req_entry_index) enter on a valid/stall channel:
// allocate hands out the lowest free index, free and insert link an entry
// into the free or active list at its sorted place, remove unlinks an entry
// from the active list. Every request yields one response (rsp_status,
// rsp_allocated_index, rsp_active_count) on a valid/stall channel.
// Allocate reads the free head's next link, then unlinks it; remove reads
// both links of the entry and joins its neighbours; free and insert walk
// the list, each step waiting on a next-link RAM read, then link the entry;
// an index of zero or beyond the table skips the lists for all but allocate.
// One request is in flight at a time; the next is accepted once the previous
// response is in the output register, even while rsp_stall holds it there.
// After reset a clearing pass rebuilds the free chain in both link RAMs;
// req_stall stays high during the pass.
// While rsp_stall is high with a response valid, the response holds and a finished request waits.
`default_nettype none
module sorted_index_list_manager #(
   parameter int ENTRIES     = 256,
   parameter int FIRST_INDEX = 1
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_operation,
   input  wire logic [7:0] req_entry_index,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_status,
   output logic [7:0]      rsp_allocated_index,
   output logic [7:0]      rsp_active_count
);
   import sil_pkg::*;

   logic           done_valid;
   logic           done_take;
   sil_result_type done_result;
   logic           rsp_valid_ff, rsp_valid_in;
   sil_result_type rsp_data_ff, rsp_data_in;

   sil_list_ctrl #(
      .ENTRIES     (ENTRIES),
      .FIRST_INDEX (FIRST_INDEX)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_entry_index (req_entry_index),
      .done_valid      (done_valid),
      .done_take       (done_take),
      .done_result     (done_result)
   );

   assign done_take = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (done_take) begin
         rsp_valid_in = done_valid;
         rsp_data_in  = done_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_data_ff.status;
   assign rsp_allocated_index = rsp_data_ff.allocated_index;
   assign rsp_active_count    = rsp_data_ff.active_count;

endmodule
`default_nettype wire
